@@ hw/rtl/scfl_pkg.sv @@
// Shared types and constants of the size-class free-list allocator.
package scfl_pkg;

  localparam int ADDR_W     = 17;
  localparam int SIZE_W     = 32;
  localparam int STAT_W     = 32;
  localparam int SIDX_W     = 4;
  localparam int FCNT_W     = 13;
  localparam int STAT_CNT   = 11;
  localparam int RECIP_W    = 32;
  localparam logic [FCNT_W-1:0] FCNT_MAX = {FCNT_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CLS_SMALL    = 2'd0,
    CLS_MEDIUM   = 2'd1,
    CLS_LARGE    = 2'd2,
    CLS_FALLBACK = 2'd3
  } cls_t;

  // Statistic indexes.
  localparam logic [SIDX_W-1:0] ST_SMALL_ALLOCS    = 4'd0;
  localparam logic [SIDX_W-1:0] ST_SMALL_HITS      = 4'd1;
  localparam logic [SIDX_W-1:0] ST_FALLBACK_ALLOCS = 4'd2;
  localparam logic [SIDX_W-1:0] ST_MEDIUM_ALLOCS   = 4'd3;
  localparam logic [SIDX_W-1:0] ST_MEDIUM_HITS     = 4'd4;
  localparam logic [SIDX_W-1:0] ST_LARGE_ALLOCS    = 4'd5;
  localparam logic [SIDX_W-1:0] ST_LARGE_HITS      = 4'd6;
  localparam logic [SIDX_W-1:0] ST_SMALL_FREES     = 4'd7;
  localparam logic [SIDX_W-1:0] ST_MEDIUM_FREES    = 4'd8;
  localparam logic [SIDX_W-1:0] ST_LARGE_FREES     = 4'd9;
  localparam logic [SIDX_W-1:0] ST_FALLBACK_FREES  = 4'd10;
  localparam logic [SIDX_W-1:0] ST_FREE_SMALL      = 4'd11;
  localparam logic [SIDX_W-1:0] ST_FREE_MEDIUM     = 4'd12;
  localparam logic [SIDX_W-1:0] ST_FREE_LARGE      = 4'd13;

  typedef struct packed {
    logic init_step;
    logic latch;
    logic div_start;
    logic commit_alloc;
    logic commit_free;
    logic commit_other;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic alloc_hit;
    logic free_hit;
    logic div_done;
  } status_t;

endpackage

@@ hw/rtl/scfl_mem.sv @@
// Simple dual-port memory holding one class's next-pointer table.
module scfl_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/scfl_div.sv @@
// Block index lookup by reciprocal multiplication, with a registered result.
module scfl_div #(
  parameter int SHIFT = 27
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [scfl_pkg::ADDR_W-1:0]  dividend,
  input  logic [scfl_pkg::RECIP_W-1:0] recip,
  output logic                         done,
  output logic [scfl_pkg::ADDR_W-1:0]  quotient
);
  import scfl_pkg::*;

  localparam int PROD_W = ADDR_W + RECIP_W;

  logic              done_r, done_nxt;
  logic [ADDR_W-1:0] quo_r, quo_nxt;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_sh;

  // The reciprocal is rounded up and the shift covers the dividend width
  // plus the divisor width, so the truncated product is the exact quotient.
  assign prod    = {{RECIP_W{1'b0}}, dividend} * {{ADDR_W{1'b0}}, recip};
  assign prod_sh = prod >> SHIFT;

  always_comb begin
    done_nxt = start;
    quo_nxt  = quo_r;
    if (start) begin
      quo_nxt = prod_sh[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hw/rtl/scfl_dp.sv @@
// Datapath: request latch, pool heads and counts, next tables, statistics.
module scfl_dp #(
  parameter int SMALL_BLOCK_BYTES  = 64,
  parameter int SMALL_BLOCK_COUNT  = 256,
  parameter int MEDIUM_BLOCK_BYTES = 256,
  parameter int MEDIUM_BLOCK_COUNT = 128,
  parameter int LARGE_BLOCK_BYTES  = 1024,
  parameter int LARGE_BLOCK_COUNT  = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  scfl_pkg::cmd_t              cmd,
  output scfl_pkg::status_t           status,
  input  logic                        cfg_we,
  input  logic                        cfg_pool_enable,
  input  logic [1:0]                  in_func,
  input  logic [scfl_pkg::SIZE_W-1:0] in_request_size,
  input  logic [scfl_pkg::ADDR_W-1:0] in_block_address,
  input  logic [scfl_pkg::SIDX_W-1:0] in_stat_index,
  output logic [scfl_pkg::ADDR_W-1:0] out_granted_address,
  output logic                        out_pool_hit,
  output logic [1:0]                  out_size_class,
  output logic [scfl_pkg::STAT_W-1:0] out_stat_value
);
  import scfl_pkg::*;

  localparam int S_AW = $clog2(SMALL_BLOCK_COUNT);
  localparam int M_AW = $clog2(MEDIUM_BLOCK_COUNT);
  localparam int L_AW = $clog2(LARGE_BLOCK_COUNT);
  localparam int S_IW = $clog2(SMALL_BLOCK_COUNT + 1);
  localparam int M_IW = $clog2(MEDIUM_BLOCK_COUNT + 1);
  localparam int L_IW = $clog2(LARGE_BLOCK_COUNT + 1);
  localparam int MAXC_SM = (SMALL_BLOCK_COUNT > MEDIUM_BLOCK_COUNT) ?
                           SMALL_BLOCK_COUNT : MEDIUM_BLOCK_COUNT;
  localparam int MAXC = (MAXC_SM > LARGE_BLOCK_COUNT) ? MAXC_SM : LARGE_BLOCK_COUNT;
  localparam int INIT_W = $clog2(MAXC);
  localparam int MAXB_SM = (SMALL_BLOCK_BYTES > MEDIUM_BLOCK_BYTES) ?
                           SMALL_BLOCK_BYTES : MEDIUM_BLOCK_BYTES;
  localparam int MAXB = (MAXB_SM > LARGE_BLOCK_BYTES) ? MAXB_SM : LARGE_BLOCK_BYTES;
  localparam int RSHIFT = ADDR_W + $clog2(MAXB);

  localparam logic [63:0] S_BYTES = 64'(SMALL_BLOCK_BYTES);
  localparam logic [63:0] M_BYTES = 64'(MEDIUM_BLOCK_BYTES);
  localparam logic [63:0] L_BYTES = 64'(LARGE_BLOCK_BYTES);
  localparam logic [63:0] S_CNT   = 64'(SMALL_BLOCK_COUNT);
  localparam logic [63:0] M_CNT   = 64'(MEDIUM_BLOCK_COUNT);
  localparam logic [63:0] L_CNT   = 64'(LARGE_BLOCK_COUNT);
  localparam logic [63:0] M_BASE  = S_BYTES * S_CNT;
  localparam logic [63:0] L_BASE  = M_BASE + M_BYTES * M_CNT;
  localparam logic [63:0] S_END   = M_BASE;
  localparam logic [63:0] M_END   = L_BASE;
  localparam logic [63:0] L_END   = L_BASE + L_BYTES * L_CNT;

  // Reciprocals of the block sizes, rounded up, scaled by 2**RSHIFT.
  localparam logic [63:0] S_RECIP = ((64'd1 << RSHIFT) + S_BYTES - 64'd1) / S_BYTES;
  localparam logic [63:0] M_RECIP = ((64'd1 << RSHIFT) + M_BYTES - 64'd1) / M_BYTES;
  localparam logic [63:0] L_RECIP = ((64'd1 << RSHIFT) + L_BYTES - 64'd1) / L_BYTES;

  // Latched request.
  func_t             func_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIDX_W-1:0] sidx_r;
  logic              en_r;

  // Pool state.
  logic [S_IW-1:0]   head_s_r, head_s_nxt;
  logic [M_IW-1:0]   head_m_r, head_m_nxt;
  logic [L_IW-1:0]   head_l_r, head_l_nxt;
  logic [FCNT_W-1:0] cnt_s_r, cnt_s_nxt;
  logic [FCNT_W-1:0] cnt_m_r, cnt_m_nxt;
  logic [FCNT_W-1:0] cnt_l_r, cnt_l_nxt;
  logic [STAT_W-1:0] stat_r [STAT_CNT];
  logic [STAT_W-1:0] stat_nxt [STAT_CNT];
  logic [INIT_W-1:0] init_cnt_r;
  logic              init_done;

  // Result registers.
  logic [ADDR_W-1:0] gaddr_r, gaddr_nxt;
  logic              hit_r, hit_nxt;
  cls_t              cls_r, cls_nxt;
  logic [STAT_W-1:0] sval_r, sval_nxt;

  // Decode.
  cls_t               pick, found;
  logic               alloc_hit, free_hit;
  logic [ADDR_W-1:0]  offset;
  logic [RECIP_W-1:0] recip;
  logic [63:0]        addr_w, grant_w, quo_w;
  logic               div_done;
  logic [ADDR_W-1:0]  quo;
  logic               b_ok;

  // Memory ports.
  logic              s_we, m_we, l_we;
  logic [S_AW-1:0]   s_wa;
  logic [M_AW-1:0]   m_wa;
  logic [L_AW-1:0]   l_wa;
  logic [S_IW-1:0]   s_wd, s_rd;
  logic [M_IW-1:0]   m_wd, m_rd;
  logic [L_IW-1:0]   l_wd, l_rd;
  logic [INIT_W:0]   init_next_val;

  assign init_done     = (init_cnt_r == INIT_W'(MAXC - 1));
  assign init_next_val = {1'b0, init_cnt_r} + 1'b1;
  assign addr_w        = 64'(addr_r);
  assign quo_w         = 64'(quo);

  always_comb begin
    if (size_r <= SIZE_W'(SMALL_BLOCK_BYTES)) begin
      pick = CLS_SMALL;
    end else if (size_r <= SIZE_W'(MEDIUM_BLOCK_BYTES)) begin
      pick = CLS_MEDIUM;
    end else if (size_r <= SIZE_W'(LARGE_BLOCK_BYTES)) begin
      pick = CLS_LARGE;
    end else begin
      pick = CLS_FALLBACK;
    end
  end

  always_comb begin
    if (addr_w < S_END) begin
      found = CLS_SMALL;
    end else if (addr_w >= M_BASE && addr_w < M_END) begin
      found = CLS_MEDIUM;
    end else if (addr_w >= L_BASE && addr_w < L_END) begin
      found = CLS_LARGE;
    end else begin
      found = CLS_FALLBACK;
    end
  end

  always_comb begin
    alloc_hit = 1'b0;
    grant_w   = '0;
    case (pick)
      CLS_SMALL: begin
        alloc_hit = (cnt_s_r != '0) && (64'(head_s_r) < S_CNT);
        grant_w   = 64'(head_s_r) * S_BYTES;
      end
      CLS_MEDIUM: begin
        alloc_hit = (cnt_m_r != '0) && (64'(head_m_r) < M_CNT);
        grant_w   = M_BASE + 64'(head_m_r) * M_BYTES;
      end
      CLS_LARGE: begin
        alloc_hit = (cnt_l_r != '0) && (64'(head_l_r) < L_CNT);
        grant_w   = L_BASE + 64'(head_l_r) * L_BYTES;
      end
      default: alloc_hit = 1'b0;
    endcase
    alloc_hit = alloc_hit && en_r && (func_r == FUNC_ALLOC);
  end

  assign free_hit = en_r && (func_r == FUNC_FREE) && (found != CLS_FALLBACK);

  always_comb begin
    case (found)
      CLS_MEDIUM: begin
        offset = addr_r - M_BASE[ADDR_W-1:0];
        recip  = M_RECIP[RECIP_W-1:0];
        b_ok   = quo_w < M_CNT;
      end
      CLS_LARGE: begin
        offset = addr_r - L_BASE[ADDR_W-1:0];
        recip  = L_RECIP[RECIP_W-1:0];
        b_ok   = quo_w < L_CNT;
      end
      default: begin
        offset = addr_r;
        recip  = S_RECIP[RECIP_W-1:0];
        b_ok   = quo_w < S_CNT;
      end
    endcase
  end

  scfl_div #(.SHIFT(RSHIFT)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (offset),
    .recip    (recip),
    .done     (div_done),
    .quotient (quo)
  );

  // Next-table write ports: reset sweep first, pushes afterwards.
  always_comb begin
    if (cmd.init_step) begin
      s_we = (32'(init_cnt_r) < SMALL_BLOCK_COUNT);
      m_we = (32'(init_cnt_r) < MEDIUM_BLOCK_COUNT);
      l_we = (32'(init_cnt_r) < LARGE_BLOCK_COUNT);
      s_wa = init_cnt_r[S_AW-1:0];
      m_wa = init_cnt_r[M_AW-1:0];
      l_wa = init_cnt_r[L_AW-1:0];
      s_wd = S_IW'(init_next_val);
      m_wd = M_IW'(init_next_val);
      l_wd = L_IW'(init_next_val);
    end else begin
      s_we = cmd.commit_free && b_ok && (found == CLS_SMALL);
      m_we = cmd.commit_free && b_ok && (found == CLS_MEDIUM);
      l_we = cmd.commit_free && b_ok && (found == CLS_LARGE);
      s_wa = quo[S_AW-1:0];
      m_wa = quo[M_AW-1:0];
      l_wa = quo[L_AW-1:0];
      s_wd = head_s_r;
      m_wd = head_m_r;
      l_wd = head_l_r;
    end
  end

  scfl_mem #(.DEPTH(SMALL_BLOCK_COUNT), .WIDTH(S_IW)) u_small_next (
    .clk (clk), .we (s_we), .waddr (s_wa), .wdata (s_wd),
    .raddr (head_s_r[S_AW-1:0]), .rdata (s_rd)
  );

  scfl_mem #(.DEPTH(MEDIUM_BLOCK_COUNT), .WIDTH(M_IW)) u_medium_next (
    .clk (clk), .we (m_we), .waddr (m_wa), .wdata (m_wd),
    .raddr (head_m_r[M_AW-1:0]), .rdata (m_rd)
  );

  scfl_mem #(.DEPTH(LARGE_BLOCK_COUNT), .WIDTH(L_IW)) u_large_next (
    .clk (clk), .we (l_we), .waddr (l_wa), .wdata (l_wd),
    .raddr (head_l_r[L_AW-1:0]), .rdata (l_rd)
  );

  // Commit of a transaction.
  always_comb begin
    head_s_nxt = head_s_r;
    head_m_nxt = head_m_r;
    head_l_nxt = head_l_r;
    cnt_s_nxt  = cnt_s_r;
    cnt_m_nxt  = cnt_m_r;
    cnt_l_nxt  = cnt_l_r;
    for (int i = 0; i < STAT_CNT; i++) begin
      stat_nxt[i] = stat_r[i];
    end
    gaddr_nxt = gaddr_r;
    hit_nxt   = hit_r;
    cls_nxt   = cls_r;
    sval_nxt  = sval_r;

    if (cmd.commit_alloc) begin
      gaddr_nxt = grant_w[ADDR_W-1:0];
      hit_nxt   = 1'b1;
      cls_nxt   = pick;
      sval_nxt  = '0;
      case (pick)
        CLS_SMALL: begin
          head_s_nxt = s_rd;
          cnt_s_nxt  = cnt_s_r - 1'b1;
          stat_nxt[ST_SMALL_ALLOCS] = stat_r[ST_SMALL_ALLOCS] + 1'b1;
          stat_nxt[ST_SMALL_HITS]   = stat_r[ST_SMALL_HITS] + 1'b1;
        end
        CLS_MEDIUM: begin
          head_m_nxt = m_rd;
          cnt_m_nxt  = cnt_m_r - 1'b1;
          stat_nxt[ST_MEDIUM_ALLOCS] = stat_r[ST_MEDIUM_ALLOCS] + 1'b1;
          stat_nxt[ST_MEDIUM_HITS]   = stat_r[ST_MEDIUM_HITS] + 1'b1;
        end
        CLS_LARGE: begin
          head_l_nxt = l_rd;
          cnt_l_nxt  = cnt_l_r - 1'b1;
          stat_nxt[ST_LARGE_ALLOCS] = stat_r[ST_LARGE_ALLOCS] + 1'b1;
          stat_nxt[ST_LARGE_HITS]   = stat_r[ST_LARGE_HITS] + 1'b1;
        end
        default: ;
      endcase
    end else if (cmd.commit_free) begin
      gaddr_nxt = '0;
      hit_nxt   = 1'b1;
      cls_nxt   = found;
      sval_nxt  = '0;
      case (found)
        CLS_SMALL: begin
          if (b_ok) head_s_nxt = quo[S_IW-1:0];
          if (cnt_s_r < FCNT_MAX) cnt_s_nxt = cnt_s_r + 1'b1;
          stat_nxt[ST_SMALL_FREES] = stat_r[ST_SMALL_FREES] + 1'b1;
        end
        CLS_MEDIUM: begin
          if (b_ok) head_m_nxt = quo[M_IW-1:0];
          if (cnt_m_r < FCNT_MAX) cnt_m_nxt = cnt_m_r + 1'b1;
          stat_nxt[ST_MEDIUM_FREES] = stat_r[ST_MEDIUM_FREES] + 1'b1;
        end
        CLS_LARGE: begin
          if (b_ok) head_l_nxt = quo[L_IW-1:0];
          if (cnt_l_r < FCNT_MAX) cnt_l_nxt = cnt_l_r + 1'b1;
          stat_nxt[ST_LARGE_FREES] = stat_r[ST_LARGE_FREES] + 1'b1;
        end
        default: ;
      endcase
    end else if (cmd.commit_other) begin
      gaddr_nxt = '0;
      hit_nxt   = 1'b0;
      cls_nxt   = CLS_SMALL;
      sval_nxt  = '0;
      case (func_r)
        FUNC_ALLOC: begin
          cls_nxt = CLS_FALLBACK;
          if (en_r) begin
            stat_nxt[ST_FALLBACK_ALLOCS] = stat_r[ST_FALLBACK_ALLOCS] + 1'b1;
          end
        end
        FUNC_FREE: begin
          cls_nxt = CLS_FALLBACK;
          if (en_r) begin
            stat_nxt[ST_FALLBACK_FREES] = stat_r[ST_FALLBACK_FREES] + 1'b1;
          end
        end
        FUNC_READ: begin
          if (sidx_r < SIDX_W'(STAT_CNT)) begin
            sval_nxt = stat_r[sidx_r];
          end else if (sidx_r == ST_FREE_SMALL) begin
            sval_nxt = STAT_W'(cnt_s_r);
          end else if (sidx_r == ST_FREE_MEDIUM) begin
            sval_nxt = STAT_W'(cnt_m_r);
          end else if (sidx_r == ST_FREE_LARGE) begin
            sval_nxt = STAT_W'(cnt_l_r);
          end
        end
        default: begin
          for (int i = 0; i < STAT_CNT; i++) begin
            stat_nxt[i] = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r       <= 1'b1;
      head_s_r   <= '0;
      head_m_r   <= '0;
      head_l_r   <= '0;
      cnt_s_r    <= FCNT_W'(SMALL_BLOCK_COUNT);
      cnt_m_r    <= FCNT_W'(MEDIUM_BLOCK_COUNT);
      cnt_l_r    <= FCNT_W'(LARGE_BLOCK_COUNT);
      init_cnt_r <= '0;
      for (int i = 0; i < STAT_CNT; i++) begin
        stat_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        en_r <= cfg_pool_enable;
      end
      if (cmd.init_step && !init_done) begin
        init_cnt_r <= init_cnt_r + 1'b1;
      end
      head_s_r <= head_s_nxt;
      head_m_r <= head_m_nxt;
      head_l_r <= head_l_nxt;
      cnt_s_r  <= cnt_s_nxt;
      cnt_m_r  <= cnt_m_nxt;
      cnt_l_r  <= cnt_l_nxt;
      for (int i = 0; i < STAT_CNT; i++) begin
        stat_r[i] <= stat_nxt[i];
      end
    end
    if (cmd.latch) begin
      func_r <= func_t'(in_func);
      size_r <= in_request_size;
      addr_r <= in_block_address;
      sidx_r <= in_stat_index;
    end
    gaddr_r <= gaddr_nxt;
    hit_r   <= hit_nxt;
    cls_r   <= cls_nxt;
    sval_r  <= sval_nxt;
  end

  assign status.init_done = init_done;
  assign status.alloc_hit = alloc_hit;
  assign status.free_hit  = free_hit;
  assign status.div_done  = div_done;

  assign out_granted_address = gaddr_r;
  assign out_pool_hit        = hit_r;
  assign out_size_class      = cls_r;
  assign out_stat_value      = sval_r;

endmodule

@@ hw/rtl/scfl_ctrl.sv @@
// Controller state machine sequencing init sweep, decode and commit.
module scfl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  input  scfl_pkg::status_t status,
  output scfl_pkg::cmd_t    cmd
);
  import scfl_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_ALLOC,
    S_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (status.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.alloc_hit) begin
          state_nxt = S_ALLOC;
        end else if (status.free_hit) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.commit_other = 1'b1;
          valid_nxt        = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_ALLOC: begin
        cmd.commit_alloc = 1'b1;
        valid_nxt        = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.commit_free = 1'b1;
          valid_nxt       = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

@@ hw/rtl/size_class_free_list_allocator.sv @@
// Top level of the three-class segregated free-list block allocator.
//
// Usage: a transaction is issued by holding start high while busy is low;
// the func, request size, block address and statistic index are sampled at
// that edge. Exactly one result comes back per transaction, on the out_
// ports for a single cycle marked by out_valid. The receiver cannot stall,
// so results are never held; busy drops in the same cycle the result is
// shown, so the next transaction can be issued alongside it.
// Reads, clears, fallbacks and disabled requests commit straight from the
// decode state; a pool allocation first passes through S_ALLOC to wait for
// the registered read of the next-pointer table, and a pool free through
// S_DIV to wait for the registered reciprocal multiply that turns the
// address into a block index. One transaction is in flight at a time.
// After reset the block stays busy while it sweeps the next-pointer
// tables into block order, up to the largest of the three block counts;
// configuration writes are taken throughout.
// The pool_enable register is written over the cfg_ channel, which is
// always ready; write it only while no transaction is in flight.
module size_class_free_list_allocator #(
  parameter int SMALL_BLOCK_BYTES  = 64,
  parameter int SMALL_BLOCK_COUNT  = 256,
  parameter int MEDIUM_BLOCK_BYTES = 256,
  parameter int MEDIUM_BLOCK_COUNT = 128,
  parameter int LARGE_BLOCK_BYTES  = 1024,
  parameter int LARGE_BLOCK_COUNT  = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request channel.
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_func,
  input  logic [scfl_pkg::SIZE_W-1:0] in_request_size,
  input  logic [scfl_pkg::ADDR_W-1:0] in_block_address,
  input  logic [scfl_pkg::SIDX_W-1:0] in_stat_index,
  // Result channel.
  output logic                        out_valid,
  output logic [scfl_pkg::ADDR_W-1:0] out_granted_address,
  output logic                        out_pool_hit,
  output logic [1:0]                  out_size_class,
  output logic [scfl_pkg::STAT_W-1:0] out_stat_value,
  // Configuration channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_pool_enable
);
  import scfl_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The single register is a plain flop, so a write always completes.
  assign cfg_ready = 1'b1;

  // The controller only sequences; all pool state lives in the datapath.
  scfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  scfl_dp #(
    .SMALL_BLOCK_BYTES  (SMALL_BLOCK_BYTES),
    .SMALL_BLOCK_COUNT  (SMALL_BLOCK_COUNT),
    .MEDIUM_BLOCK_BYTES (MEDIUM_BLOCK_BYTES),
    .MEDIUM_BLOCK_COUNT (MEDIUM_BLOCK_COUNT),
    .LARGE_BLOCK_BYTES  (LARGE_BLOCK_BYTES),
    .LARGE_BLOCK_COUNT  (LARGE_BLOCK_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_pool_enable     (cfg_pool_enable),
    .in_func             (in_func),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .in_stat_index       (in_stat_index),
    .out_granted_address (out_granted_address),
    .out_pool_hit        (out_pool_hit),
    .out_size_class      (out_size_class),
    .out_stat_value      (out_stat_value)
  );

endmodule

@@ test/tb_size_class_free_list_allocator.sv @@
// Self-checking testbench for the three-class segregated free-list allocator.
`timescale 1ns / 100ps

module tb_size_class_free_list_allocator;
  import scfl_pkg::*;

  // Pool geometry, kept equal to the parameters handed to the block.
  localparam int unsigned SMALL_BYTES  = 64;
  localparam int unsigned SMALL_COUNT  = 256;
  localparam int unsigned MEDIUM_BYTES = 256;
  localparam int unsigned MEDIUM_COUNT = 128;
  localparam int unsigned LARGE_BYTES  = 1024;
  localparam int unsigned LARGE_COUNT  = 64;
  localparam int unsigned POOL_END     = SMALL_BYTES * SMALL_COUNT +
                                         MEDIUM_BYTES * MEDIUM_COUNT +
                                         LARGE_BYTES * LARGE_COUNT;
  localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  // Cycles allowed after the last result for stray strobes to show up.
  localparam int DRAIN_CYCLES = 25;
  localparam int GAP_PCT = 12;

  typedef struct {
    func_t               func;
    logic [SIZE_W-1:0]   size;
    logic [ADDR_W-1:0]   addr;
    logic [SIDX_W-1:0]   sidx;
  } alloc_request_t;

  typedef struct {
    logic [ADDR_W-1:0]   granted;
    logic                hit;
    cls_t                cls;
    logic [STAT_W-1:0]   value;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_func = FUNC_READ;
  logic [SIZE_W-1:0]   in_request_size = '0;
  logic [ADDR_W-1:0]   in_block_address = '0;
  logic [SIDX_W-1:0]   in_stat_index = '0;

  logic                out_valid;
  logic [ADDR_W-1:0]   out_granted_address;
  logic                out_pool_hit;
  logic [1:0]          out_size_class;
  logic [STAT_W-1:0]   out_stat_value;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_pool_enable = 1'b0;

  // Shadow copy of the allocator state that the predictor works on.
  logic              pools_on;
  logic [FCNT_W-1:0] next_ptr [3][SMALL_COUNT];
  logic [FCNT_W-1:0] head_ptr [3];
  logic [FCNT_W-1:0] free_cnt [3];
  logic [STAT_W-1:0] stat_cnt [STAT_CNT];

  alloc_request_t    pending_requests [$];
  alloc_result_t     expected_results [$];
  logic              pending_enables [$];

  // Addresses currently handed out by the pools; the stimulus frees these
  // so that most frees return a block that is really in use.
  logic [ADDR_W-1:0] live_blocks [$];
  logic [ADDR_W-1:0] last_freed = '0;

  logic gap_free = 1'b0;
  int   mismatch_count = 0;
  int   idle_cycles = 0;

  size_class_free_list_allocator #(
    .SMALL_BLOCK_BYTES  (SMALL_BYTES),
    .SMALL_BLOCK_COUNT  (SMALL_COUNT),
    .MEDIUM_BLOCK_BYTES (MEDIUM_BYTES),
    .MEDIUM_BLOCK_COUNT (MEDIUM_COUNT),
    .LARGE_BLOCK_BYTES  (LARGE_BYTES),
    .LARGE_BLOCK_COUNT  (LARGE_COUNT)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .in_stat_index       (in_stat_index),
    .out_valid           (out_valid),
    .out_granted_address (out_granted_address),
    .out_pool_hit        (out_pool_hit),
    .out_size_class      (out_size_class),
    .out_stat_value      (out_stat_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_pool_enable     (cfg_pool_enable)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned block_bytes(input int c);
    case (c)
      0:       return SMALL_BYTES;
      1:       return MEDIUM_BYTES;
      default: return LARGE_BYTES;
    endcase
  endfunction

  function automatic int unsigned block_count(input int c);
    case (c)
      0:       return SMALL_COUNT;
      1:       return MEDIUM_COUNT;
      default: return LARGE_COUNT;
    endcase
  endfunction

  // Regions sit end to end from offset zero: small, medium, then large.
  function automatic int unsigned region_base(input int c);
    case (c)
      0:       return 0;
      1:       return SMALL_BYTES * SMALL_COUNT;
      default: return SMALL_BYTES * SMALL_COUNT + MEDIUM_BYTES * MEDIUM_COUNT;
    endcase
  endfunction

  // Brings the shadow state to its power-up contents: every free list in
  // ascending block order, heads at block zero, counters cleared.
  task automatic reset_allocator_state();
    pools_on = 1'b1;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < SMALL_COUNT; i++) next_ptr[c][i] = FCNT_W'(i + 1);
      head_ptr[c] = '0;
      free_cnt[c] = FCNT_W'(block_count(c));
    end
    for (int i = 0; i < STAT_CNT; i++) stat_cnt[i] = '0;
  endtask

  function automatic void bump_stat(input logic [SIDX_W-1:0] idx);
    stat_cnt[idx] = stat_cnt[idx] + 1'b1;
  endfunction

  // Works out the one result of a request and advances the shadow state.
  function automatic alloc_result_t serve_request(input alloc_request_t req);
    alloc_result_t     r;
    int                pick;
    int unsigned       a;
    int unsigned       blk;
    logic [FCNT_W-1:0] h;
    logic [SIDX_W-1:0] idx;
    r.granted = '0;
    r.hit     = 1'b0;
    r.cls     = CLS_SMALL;
    r.value   = '0;
    case (req.func)
      FUNC_ALLOC: begin
        r.cls = CLS_FALLBACK;
        if (pools_on) begin
          // Smallest class whose block is big enough.
          pick = 3;
          for (int c = 2; c >= 0; c--) if (req.size <= block_bytes(c)) pick = c;
          // A class is exhausted when its count is zero or its head has run
          // off the end of the table; both fall back.
          if (pick < 3 && free_cnt[pick] != 0 && head_ptr[pick] < block_count(pick)) begin
            h = head_ptr[pick];
            head_ptr[pick] = next_ptr[pick][h];
            free_cnt[pick] = free_cnt[pick] - 1'b1;
            r.granted = ADDR_W'(region_base(pick) + int'(h) * block_bytes(pick));
            r.hit = 1'b1;
            r.cls = cls_t'(pick);
            case (pick)
              0:       idx = ST_SMALL_ALLOCS;
              1:       idx = ST_MEDIUM_ALLOCS;
              default: idx = ST_LARGE_ALLOCS;
            endcase
            // The pool-hit counter of each class follows its alloc counter.
            bump_stat(idx);
            bump_stat(idx + 1'b1);
            live_blocks.push_back(r.granted);
          end else begin
            bump_stat(ST_FALLBACK_ALLOCS);
          end
        end
      end
      FUNC_FREE: begin
        r.cls = CLS_FALLBACK;
        if (pools_on) begin
          a = 32'(req.addr);
          pick = 3;
          for (int c = 0; c < 3; c++)
            if (pick == 3 && a >= region_base(c) &&
                a < region_base(c) + block_bytes(c) * block_count(c)) pick = c;
          if (pick < 3) begin
            // A misaligned address lands on the block that holds it, and a
            // block freed twice is simply pushed again.
            blk = (a - region_base(pick)) / block_bytes(pick);
            next_ptr[pick][blk] = head_ptr[pick];
            head_ptr[pick] = FCNT_W'(blk);
            if (free_cnt[pick] < FCNT_MAX) free_cnt[pick] = free_cnt[pick] + 1'b1;
            r.hit = 1'b1;
            r.cls = cls_t'(pick);
            bump_stat(ST_SMALL_FREES + SIDX_W'(pick));
          end else begin
            bump_stat(ST_FALLBACK_FREES);
          end
        end
      end
      FUNC_READ: begin
        if (req.sidx < STAT_CNT) r.value = stat_cnt[req.sidx];
        else if (req.sidx <= ST_FREE_LARGE) r.value = STAT_W'(free_cnt[req.sidx - ST_FREE_SMALL]);
      end
      default: begin
        for (int i = 0; i < STAT_CNT; i++) stat_cnt[i] = '0;
      end
    endcase
    return r;
  endfunction

  // Request driver. A transaction is taken at an edge with start high and
  // busy low; its expected result is predicted right there. Start is then
  // either kept up with the next request or dropped, never both.
  always @(posedge clk) begin : drive_requests
    alloc_request_t taken;
    alloc_request_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        taken.func = func_t'(in_func);
        taken.size = in_request_size;
        taken.addr = in_block_address;
        taken.sidx = in_stat_index;
        expected_results.push_back(serve_request(taken));
      end
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && (gap_free || $urandom_range(99) >= GAP_PCT)) begin
          nxt = pending_requests.pop_front();
          in_func          <= nxt.func;
          in_request_size  <= nxt.size;
          in_block_address <= nxt.addr;
          in_stat_index    <= nxt.sidx;
          start            <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Configuration writer. The shadow enable follows each accepted write;
  // writes are only queued while no request is in flight.
  always @(posedge clk) begin : drive_config
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) pools_on = cfg_pool_enable;
      if (!cfg_valid || cfg_ready) begin
        if (pending_enables.size() != 0) begin
          cfg_pool_enable <= pending_enables.pop_front();
          cfg_valid       <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input alloc_result_t want);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected addr %0d hit %0b class %0d value %0d, got addr %0d hit %0b class %0d value %0d",
               $realtime, what, want.granted, want.hit, want.cls, want.value,
               out_granted_address, out_pool_hit, out_size_class, out_stat_value);
  endtask

  // Result checker. Results cannot be held off, so every strobe is taken.
  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        want = '{granted: '0, hit: 1'b0, cls: CLS_SMALL, value: '0};
        report_mismatch("result with no request outstanding", want);
      end else begin
        want = expected_results.pop_front();
        if (out_granted_address !== want.granted || out_pool_hit !== want.hit ||
            out_size_class !== want.cls || out_stat_value !== want.value)
          report_mismatch("result mismatch", want);
      end
    end
  end

  // Watchdog on cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("size_class_free_list_allocator verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Waits until every request has gone through and its result came back.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0 ||
           pending_enables.size() != 0 || cfg_valid)
      @(negedge clk);
  endtask

  task automatic write_pool_enable(input logic value);
    wait_idle();
    pending_enables.push_back(value);
    wait_idle();
  endtask

  // Keeps the request queue short so that frees can pick from blocks that
  // were granted only a few transactions earlier.
  task automatic queue_request(input func_t f, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr, input logic [SIDX_W-1:0] sidx);
    alloc_request_t req;
    while (pending_requests.size() > 4) @(negedge clk);
    req.func = f;
    req.size = size;
    req.addr = addr;
    req.sidx = sidx;
    pending_requests.push_back(req);
  endtask

  // Request sizes aimed at one class at a time, with some oversized ones
  // and some drawn over the whole 32-bit range.
  function automatic logic [SIZE_W-1:0] pick_size(input int small_pct);
    int r;
    r = $urandom_range(99);
    if (r < small_pct) return $urandom_range(SMALL_BYTES);
    r = $urandom_range(99);
    if (r < 45) return $urandom_range(MEDIUM_BYTES, SMALL_BYTES + 1);
    if (r < 88) return $urandom_range(LARGE_BYTES, MEDIUM_BYTES + 1);
    if (r < 94) return $urandom_range(2 * LARGE_BYTES, LARGE_BYTES + 1);
    return $urandom;
  endfunction

  // One stretch of random traffic. Most frees return a block that is in
  // use; the rest are double frees, pool addresses picked blindly and
  // addresses anywhere in the space.
  task automatic random_round(input int n, input int alloc_pct, input int free_pct,
                              input int small_pct);
    int                r;
    int                k;
    int                j;
    func_t             f;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < n; i++) begin
      r    = $urandom_range(99);
      size = $urandom;
      addr = ADDR_W'($urandom_range(ADDR_TOP));
      if (r < alloc_pct) begin
        f    = FUNC_ALLOC;
        size = pick_size(small_pct);
      end else if (r < alloc_pct + free_pct) begin
        f = FUNC_FREE;
        k = $urandom_range(99);
        if (k < 75 && live_blocks.size() != 0) begin
          j = $urandom_range(live_blocks.size() - 1);
          // Now and then the address points inside the block, not at it.
          addr = live_blocks[j] + ((k < 10) ? ADDR_W'($urandom_range(SMALL_BYTES - 1)) : '0);
          last_freed = live_blocks[j];
          live_blocks.delete(j);
        end else if (k < 85) begin
          addr = last_freed;
        end else if (k < 93) begin
          addr = ADDR_W'($urandom_range(POOL_END - 1)) & ~ADDR_W'(SMALL_BYTES - 1);
        end
      end else if (r < 98) begin
        f = FUNC_READ;
      end else begin
        f = FUNC_CLEAR;
      end
      queue_request(f, size, addr, SIDX_W'($urandom_range(15)));
    end
  endtask

  initial begin
    reset_allocator_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The block sweeps its tables after reset but takes writes meanwhile.
    write_pool_enable(1'b1);

    // Class boundaries: each block size and one byte past it, plus the
    // smallest and largest sizes.
    queue_request(FUNC_ALLOC, 32'd0, ADDR_W'($urandom), SIDX_W'($urandom));
    queue_request(FUNC_ALLOC, 32'd64, ADDR_W'($urandom), SIDX_W'($urandom));
    queue_request(FUNC_ALLOC, 32'd65, ADDR_W'($urandom), SIDX_W'($urandom));
    queue_request(FUNC_ALLOC, 32'd256, ADDR_W'($urandom), SIDX_W'($urandom));
    queue_request(FUNC_ALLOC, 32'd257, ADDR_W'($urandom), SIDX_W'($urandom));
    queue_request(FUNC_ALLOC, 32'd1024, ADDR_W'($urandom), SIDX_W'($urandom));
    queue_request(FUNC_ALLOC, 32'd1025, ADDR_W'($urandom), SIDX_W'($urandom));
    queue_request(FUNC_ALLOC, 32'hFFFF_FFFF, ADDR_W'($urandom), SIDX_W'($urandom));
    // Frees: misaligned, the last byte of the small region (a block that is still free,
    // so a double free), the medium region start, the last byte of the first large block,
    // the last pool byte, the first byte past the pools and the top of the address space.
    queue_request(FUNC_FREE, $urandom, 17'd81, SIDX_W'($urandom));
    queue_request(FUNC_FREE, $urandom, 17'd16383, SIDX_W'($urandom));
    queue_request(FUNC_FREE, $urandom, 17'd16384, SIDX_W'($urandom));
    queue_request(FUNC_FREE, $urandom, 17'd50175, SIDX_W'($urandom));
    queue_request(FUNC_FREE, $urandom, 17'(POOL_END - 1), SIDX_W'($urandom));
    queue_request(FUNC_FREE, $urandom, 17'(POOL_END), SIDX_W'($urandom));
    queue_request(FUNC_FREE, $urandom, ADDR_TOP, SIDX_W'($urandom));
    // The last block pushed comes back first.
    queue_request(FUNC_ALLOC, 32'd1, ADDR_W'($urandom), SIDX_W'($urandom));
    queue_request(FUNC_FREE, $urandom, 17'd0, SIDX_W'($urandom));
    queue_request(FUNC_READ, $urandom, ADDR_W'($urandom), ST_SMALL_ALLOCS);
    queue_request(FUNC_READ, $urandom, ADDR_W'($urandom), ST_FALLBACK_ALLOCS);
    queue_request(FUNC_READ, $urandom, ADDR_W'($urandom), ST_FALLBACK_FREES);
    queue_request(FUNC_READ, $urandom, ADDR_W'($urandom), ST_FREE_SMALL);
    queue_request(FUNC_READ, $urandom, ADDR_W'($urandom), ST_FREE_LARGE);
    queue_request(FUNC_READ, $urandom, ADDR_W'($urandom), 4'd15);
    queue_request(FUNC_CLEAR, $urandom, ADDR_W'($urandom), SIDX_W'($urandom));
    queue_request(FUNC_READ, $urandom, ADDR_W'($urandom), ST_FALLBACK_ALLOCS);

    // Alloc-heavy traffic that runs the medium and large classes dry.
    random_round(300, 75, 15, 30);

    // With the pools off, allocs and frees fall back and change nothing.
    write_pool_enable(1'b0);
    random_round(40, 40, 40, 50);
    write_pool_enable(1'b1);

    // Free-heavy traffic refills the lists in scrambled order.
    random_round(250, 20, 70, 30);

    // Small requests back to back, without gaps, to exhaust that class too.
    gap_free = 1'b1;
    random_round(300, 75, 15, 85);
    gap_free = 1'b0;

    random_round(100, 45, 45, 40);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += expected_results.size();
    if (mismatch_count == 0) begin
      $display("size_class_free_list_allocator verification clean");
    end else begin
      $display("size_class_free_list_allocator verification failed");
    end
    $finish;
  end

endmodule
